// File: rtl/elu_pkg.sv
package elu_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 12;

   // exp(-t) arithmetic is done with 32 fractional bits
   localparam logic [31:0] LN2_Q32    = 32'hB17217F8;
   localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
   localparam int          N_TERMS    = 13;
   localparam int          TERM_IDX_W = 4;
   localparam int          SUM_W      = 35;
   localparam int          EXP_ZERO_Q = 40;

   // t = |x| with 32 fractional bits
   localparam int T_W  = DATA_WIDTH + 32 - FRAC_BITS;
   // q = floor(t / ln2) fits in QW bits
   localparam int QW   = DATA_WIDTH - FRAC_BITS + 1;
   // q_est = (|x| * RECIP_LN2) >> DATA_WIDTH, low by at most one
   localparam logic [QW-1:0] RECIP_LN2 =
      QW'((64'd1 << (32 - FRAC_BITS + DATA_WIDTH)) / 64'hB17217F8);

   localparam logic [32:0] SERIES_RECIP [16] = '{
      33'd0,
      33'(64'd4294967296 / 64'd1),
      33'(64'd4294967296 / 64'd2),
      33'(64'd4294967296 / 64'd3),
      33'(64'd4294967296 / 64'd4),
      33'(64'd4294967296 / 64'd5),
      33'(64'd4294967296 / 64'd6),
      33'(64'd4294967296 / 64'd7),
      33'(64'd4294967296 / 64'd8),
      33'(64'd4294967296 / 64'd9),
      33'(64'd4294967296 / 64'd10),
      33'(64'd4294967296 / 64'd11),
      33'(64'd4294967296 / 64'd12),
      33'(64'd4294967296 / 64'd13),
      33'd0,
      33'd0
   };

   localparam logic [DATA_WIDTH-1:0] SLOPE_RESET = DATA_WIDTH'(1) << FRAC_BITS;
   localparam logic [DATA_WIDTH:0]   RES_MAX     = (DATA_WIDTH+1)'((1 << (DATA_WIDTH-1)) - 1);

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sample;
      logic                         last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result;
      logic                         last_out;
   } rsp_type;

   typedef struct packed {
      logic                         pos;
      logic signed [DATA_WIDTH-1:0] sample;
      logic                         last;
      logic [QW-1:0]                q;
   } ctx_type;

   typedef struct packed {
      ctx_type                 ctx;
      logic [31:0]             r;
      logic [32:0]             term;
      logic signed [SUM_W-1:0] sum;
   } series_type;

endpackage

// File: rtl/elu_range_reduce.sv
module elu_range_reduce (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  elu_pkg::req_type    in_data,
   output logic                out_valid,
   output elu_pkg::series_type out_data
);
   import elu_pkg::*;

   logic [2:0] valid_ff, valid_in;

   // stage 1: magnitude and quotient estimate
   logic                       pos_s1;
   logic [DATA_WIDTH-1:0]      mag_s1;
   logic [DATA_WIDTH+QW-1:0]   qprod_s1;
   logic [DATA_WIDTH-1:0]      mag_ff, mag_in;
   ctx_type                    ctx1_ff, ctx1_in;

   // stage 2: remainder before correction
   logic [T_W-1:0]             t_s2;
   logic [QW+31:0]             qln_s2;
   logic [T_W-1:0]             rem_s2;
   logic [32:0]                r0_ff, r0_in;
   ctx_type                    ctx2_ff;

   // stage 3: one correction step
   series_type                 out_ff, out_in;

   assign valid_in = {valid_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      pos_s1   = !in_data.sample[DATA_WIDTH-1] && (in_data.sample != '0);
      mag_s1   = DATA_WIDTH'(-in_data.sample);
      mag_in   = pos_s1 ? '0 : mag_s1;
      qprod_s1 = (DATA_WIDTH+QW)'(mag_in) * (DATA_WIDTH+QW)'(RECIP_LN2);
      ctx1_in.pos    = pos_s1;
      ctx1_in.sample = in_data.sample;
      ctx1_in.last   = in_data.last;
      ctx1_in.q      = qprod_s1[DATA_WIDTH+QW-1:DATA_WIDTH];
   end

   always_comb begin
      t_s2   = T_W'(mag_ff) << (32 - FRAC_BITS);
      qln_s2 = (QW+32)'(ctx1_ff.q) * (QW+32)'(LN2_Q32);
      rem_s2 = t_s2 - T_W'(qln_s2);
      r0_in  = rem_s2[32:0];
   end

   always_comb begin
      out_in.ctx  = ctx2_ff;
      out_in.term = ONE_Q32;
      out_in.sum  = SUM_W'(ONE_Q32);
      if (r0_ff >= {1'b0, LN2_Q32}) begin
         out_in.ctx.q = ctx2_ff.q + QW'(1);
         out_in.r     = 32'(r0_ff - {1'b0, LN2_Q32});
      end else begin
         out_in.r     = r0_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag_in;
         ctx1_ff <= ctx1_in;
         r0_ff   <= r0_in;
         ctx2_ff <= ctx1_ff;
         out_ff  <= out_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = out_ff;

endmodule

// File: rtl/elu_series_term.sv
module elu_series_term (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [elu_pkg::TERM_IDX_W-1:0] term_n,
   input  logic                          in_valid,
   input  elu_pkg::series_type           in_data,
   output logic                          out_valid,
   output elu_pkg::series_type           out_data
);
   import elu_pkg::*;

   logic [2:0]  valid_ff, valid_in;

   // a: term * r, b: divide by n through the reciprocal, c: fix up and accumulate
   logic [64:0] mul_a;
   logic [31:0] p_ff, p_in;
   series_type  da_ff;

   logic [64:0] mul_b;
   logic [31:0] est_ff, est_in;
   logic [31:0] pb_ff;
   series_type  db_ff;

   logic [35:0] back_c;
   logic [31:0] rem_c;
   logic [31:0] quo_c;
   series_type  out_ff, out_in;

   assign valid_in = {valid_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      mul_a  = 65'(in_data.term) * 65'(in_data.r);
      p_in   = mul_a[63:32];
      mul_b  = 65'(p_ff) * 65'(SERIES_RECIP[term_n]);
      est_in = mul_b[63:32];
   end

   always_comb begin
      back_c = 36'(est_ff) * 36'(term_n);
      rem_c  = pb_ff - back_c[31:0];
      quo_c  = (rem_c >= 32'(term_n)) ? est_ff + 32'd1 : est_ff;
      out_in      = db_ff;
      out_in.term = {1'b0, quo_c};
      if (term_n[0]) begin
         out_in.sum = db_ff.sum - SUM_W'(quo_c);
      end else begin
         out_in.sum = db_ff.sum + SUM_W'(quo_c);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= p_in;
         da_ff  <= in_data;
         est_ff <= est_in;
         pb_ff  <= p_ff;
         db_ff  <= da_ff;
         out_ff <= out_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = out_ff;

endmodule

// File: rtl/elu_output_stage.sv
module elu_output_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  elu_pkg::series_type in_data,
   input  elu_pkg::data_type   slope,
   output logic                out_valid,
   output elu_pkg::rsp_type    out_data
);
   import elu_pkg::*;

   localparam int PW = DATA_WIDTH + 33;

   logic [2:0]  valid_ff, valid_in;

   // stage 1: clamp series, scale by 2^-q, form 1 - e
   logic [32:0] clamp_s1;
   logic [32:0] e_s1;
   logic [32:0] em1_ff, em1_in;
   ctx_type     ctx1_ff;

   // stage 2: times |slope|
   logic [DATA_WIDTH-1:0] smag_s2;
   logic [PW-1:0]         prod_ff, prod_in;
   logic                  sneg_ff, sneg_in;
   ctx_type               ctx2_ff;

   // stage 3: round, sign, saturate
   logic [PW-1:0]         round_s3;
   logic [DATA_WIDTH:0]   mag_s3;
   rsp_type               out_ff, out_in;

   assign valid_in = {valid_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      if (in_data.sum[SUM_W-1]) begin
         clamp_s1 = '0;
      end else if (in_data.sum > $signed(SUM_W'(ONE_Q32))) begin
         clamp_s1 = ONE_Q32;
      end else begin
         clamp_s1 = in_data.sum[32:0];
      end
      if (32'(in_data.ctx.q) >= 32'(EXP_ZERO_Q)) begin
         e_s1 = '0;
      end else begin
         e_s1 = clamp_s1 >> in_data.ctx.q;
      end
      em1_in = ONE_Q32 - e_s1;
   end

   always_comb begin
      smag_s2 = slope[DATA_WIDTH-1] ? DATA_WIDTH'(-slope) : slope;
      prod_in = PW'(smag_s2) * PW'(em1_ff);
      // positive slope flips the sign of the result
      sneg_in = !slope[DATA_WIDTH-1] && (slope != '0);
   end

   always_comb begin
      round_s3 = prod_ff + PW'(33'h0_8000_0000);
      mag_s3   = round_s3[PW-1:32];
      out_in.last_out = ctx2_ff.last;
      if (ctx2_ff.pos) begin
         out_in.result = ctx2_ff.sample;
      end else if (sneg_ff) begin
         out_in.result = DATA_WIDTH'(-mag_s3);
      end else if (mag_s3 > RES_MAX) begin
         out_in.result = RES_MAX[DATA_WIDTH-1:0];
      end else begin
         out_in.result = mag_s3[DATA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         em1_ff  <= em1_in;
         ctx1_ff <= in_data.ctx;
         prod_ff <= prod_in;
         sneg_ff <= sneg_in;
         ctx2_ff <= ctx1_ff;
         out_ff  <= out_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = out_ff;

endmodule

// File: rtl/elu_activation_unit.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  req_data  (sample, last)
// rsp_      out        rsp_valid/rsp_ready  rsp_data  (result, last_out)
// csr_      in         csr_write_en         csr_write_data (slope)
//
// One request per cycle unless the pipeline holds; each request goes through
// range reduction, one slice per series term over 13 terms, and the output scaling.
// Each series term is computed in a three-stage slice.
// Synchronous reset clears all valid bits and sets slope to 1.0.
// When a result waits with rsp_ready low the whole pipeline holds.
module elu_activation_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  elu_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output elu_pkg::rsp_type  rsp_data,
   input  logic              csr_write_en,
   input  elu_pkg::data_type csr_write_data
);
   import elu_pkg::*;

   logic       en;
   data_type   slope_ff, slope_in;
   logic       chain_valid [N_TERMS+1];
   series_type chain_data  [N_TERMS+1];

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   assign slope_in = csr_write_en ? csr_write_data : slope_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff <= SLOPE_RESET;
      end else begin
         slope_ff <= slope_in;
      end
   end

   elu_range_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   for (genvar g = 0; g < N_TERMS; g++) begin : g_term
      elu_series_term u_term (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .term_n    (TERM_IDX_W'(g + 1)),
         .in_valid  (chain_valid[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   elu_output_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (chain_valid[N_TERMS]),
      .in_data   (chain_data[N_TERMS]),
      .slope     (slope_ff),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

// File: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import elu_pkg::*;

   localparam longint unsigned LN2_FIX     = 64'hB17217F8;
   localparam longint unsigned UNIT_FIX    = 64'h1_0000_0000;
   localparam int              EXP_TERMS   = 14;
   localparam int              UNDERFLOW_Q = 40;
   localparam longint          RES_HI      = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
   localparam longint          RES_LO      = -RES_HI - 1;
   localparam int              CYCLE_LIMIT = 200000;
   localparam int              SEG_COUNT   = 8;
   localparam int              SEG_ITEMS   = 200;
   localparam int              HOLD_CYCLES = 300;
   localparam int              REPORT_MAX  = 10;

   typedef struct {
      data_type slope;
      req_type  req;
      bit       known;
      rsp_type  want;
   } directed_row_type;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   req_type  req_data;
   logic     rsp_valid;
   logic     rsp_ready;
   rsp_type  rsp_data;
   logic     csr_write_en;
   data_type csr_write_data;

   rsp_type  pending_results[$];
   data_type slope_model;
   bit       cur_known;
   rsp_type  cur_want;
   int       mismatches;
   int       cycle_count;
   int       send_idle_pct;
   int       recv_idle_pct;
   int       stall_left;

   elu_activation_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ELU of one sample: exp(-t) by range reduction on ln2 and a Taylor series in Q32
   function automatic rsp_type elu_of(req_type item, data_type slope_v);
      longint          x;
      longint          s;
      longint          y;
      longint          acc;
      longint unsigned t;
      longint unsigned q;
      longint unsigned rem;
      longint unsigned term;
      longint unsigned e;
      longint unsigned em1;
      longint unsigned smag;
      longint unsigned mag;
      rsp_type         o;
      x = item.sample;
      s = slope_v;
      if (x > 0) begin
         y = x;
      end else begin
         t = (-x) << (32 - FRAC_BITS);
         q = t / LN2_FIX;
         rem = t - q * LN2_FIX;
         if (q >= UNDERFLOW_Q) begin
            e = 0;
         end else begin
            term = UNIT_FIX;
            acc = UNIT_FIX;
            for (int n = 1; n < EXP_TERMS; n++) begin
               term = ((term * rem) >> 32) / n;
               if (n % 2 == 1) acc = acc - $signed(term);
               else acc = acc + $signed(term);
            end
            if (acc < 0) acc = 0;
            if (acc > $signed(UNIT_FIX)) acc = UNIT_FIX;
            e = $unsigned(acc) >> q;
         end
         em1 = UNIT_FIX - e;
         smag = (s < 0) ? -s : s;
         mag = (smag * em1 + 64'h8000_0000) >> 32;
         y = (s > 0) ? -$signed(mag) : $signed(mag);
         if (y > RES_HI) y = RES_HI;
         if (y < RES_LO) y = RES_LO;
      end
      o.result = y[DATA_WIDTH-1:0];
      o.last_out = item.last;
      return o;
   endfunction

   function automatic data_type pick_sample();
      data_type edges[6];
      int       v;
      edges = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            v = $urandom_range(0, 32768);
            return data_type'(-v);
         end
         4: begin
            v = $urandom_range(0, 64);
            return data_type'(-v);
         end
         5: return edges[$urandom_range(0, 5)];
         6, 7: return data_type'($urandom_range(1, 32767));
         default: return data_type'($urandom);
      endcase
   endfunction

   task automatic note_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("MISMATCH %s: expected result=%0d last=%0b, got result=%0d last=%0b",
                  what, want.result, want.last_out, got.result, got.last_out);
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // scoreboard; sampled at the rising edge before the block updates
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               note_mismatch("unexpected result", '0, rsp_data);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.result !== want.result)
                  note_mismatch("result field", want, rsp_data);
               else if (rsp_data.last_out !== want.last_out)
                  note_mismatch("last_out field", want, rsp_data);
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(cur_known ? cur_want : elu_of(req_data, slope_model));
         if (csr_write_en)
            slope_model = csr_write_data;
      end
   end

   // receiver; a long hold-off overrides the random backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // entered and left at a falling edge
   task automatic send_request(req_type item, bit known, rsp_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = item;
      cur_known = known;
      cur_want = want;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_slope(data_type v);
      csr_write_en = 1'b1;
      csr_write_data = v;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic set_pace(int send_pct, int recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      @(negedge clock);
   endtask

   directed_row_type rows[$];
   data_type         seg_slopes[SEG_COUNT];

   initial begin
      req_type item;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      slope_model = SLOPE_RESET;
      cur_known = 1'b0;
      cur_want = '0;
      mismatches = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_left = 0;

      // slope 1.0 out of reset; pass-through and zero rows are typed in
      rows.push_back('{16'sd4096, '{16'sd0, 1'b0}, 1'b1, '{16'sd0, 1'b0}});
      rows.push_back('{16'sd4096, '{16'sd1, 1'b1}, 1'b1, '{16'sd1, 1'b1}});
      rows.push_back('{16'sd4096, '{16'sh7FFF, 1'b0}, 1'b1, '{16'sh7FFF, 1'b0}});
      rows.push_back('{16'sd4096, '{16'sh5555, 1'b1}, 1'b1, '{16'sh5555, 1'b1}});
      rows.push_back('{16'sd4096, '{16'sd4096, 1'b0}, 1'b1, '{16'sd4096, 1'b0}});
      rows.push_back('{16'sd4096, '{16'sh8000, 1'b0}, 1'b0, '0});
      rows.push_back('{16'sd4096, '{-16'sd1, 1'b1}, 1'b0, '0});
      rows.push_back('{16'sd4096, '{-16'sd4096, 1'b0}, 1'b0, '0});
      rows.push_back('{16'sd4096, '{16'shAAAA, 1'b0}, 1'b0, '0});
      rows.push_back('{16'sd4096, '{-16'sd2048, 1'b1}, 1'b0, '0});
      // negative slope flips the sign of the negative branch, then the largest positive slope
      rows.push_back('{16'sh8000, '{16'sh8000, 1'b0}, 1'b0, '0});
      rows.push_back('{16'sh8000, '{16'sd0, 1'b1}, 1'b1, '{16'sd0, 1'b1}});
      rows.push_back('{16'sh8000, '{16'sh7FFF, 1'b0}, 1'b1, '{16'sh7FFF, 1'b0}});
      rows.push_back('{16'sh8000, '{-16'sd3, 1'b0}, 1'b0, '0});
      rows.push_back('{16'sh7FFF, '{16'sh8000, 1'b1}, 1'b0, '0});
      rows.push_back('{16'sh7FFF, '{-16'sd1, 1'b0}, 1'b0, '0});
      rows.push_back('{16'sh7FFF, '{16'sh8001, 1'b0}, 1'b0, '0});
      // zero slope kills the negative branch
      rows.push_back('{16'sd0, '{16'sh8000, 1'b0}, 1'b1, '{16'sd0, 1'b0}});
      rows.push_back('{16'sd0, '{-16'sd100, 1'b1}, 1'b1, '{16'sd0, 1'b1}});
      rows.push_back('{16'sd0, '{16'sd300, 1'b0}, 1'b1, '{16'sd300, 1'b0}});

      seg_slopes[0] = 16'sh8000;
      seg_slopes[1] = 16'sh7FFF;
      seg_slopes[2] = data_type'($urandom);
      seg_slopes[3] = 16'sd0;
      seg_slopes[4] = -16'sd4096;
      seg_slopes[5] = data_type'($urandom);
      seg_slopes[6] = 16'sd4096;
      seg_slopes[7] = 16'sd1;

      repeat (12) @(negedge clock);
      reset = 1'b0;

      set_pace(12, 60);
      foreach (rows[i]) begin
         if (rows[i].slope != slope_model) begin
            drain_results();
            write_slope(rows[i].slope);
         end
         send_request(rows[i].req, rows[i].known, rows[i].want);
      end

      for (int seg = 0; seg < SEG_COUNT; seg++) begin
         drain_results();
         if (seg == 3) set_pace(60, 12);
         if (seg == 6) set_pace(0, 0);
         write_slope(seg_slopes[seg]);
         for (int k = 0; k < SEG_ITEMS; k++) begin
            // long receiver hold-off while requests keep coming: pipeline fills
            if (seg == 1 && k == 50) begin
               req_valid = 1'b0;
               @(posedge clock);
               stall_left = HOLD_CYCLES;
               @(negedge clock);
            end
            if (seg == 4 && k == 100) drain_results();
            item.sample = pick_sample();
            item.last = ($urandom_range(0, 15) == 0);
            send_request(item, 1'b0, '0);
         end
      end

      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
